@@ sv/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, constants and helpers shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] ReplChar   = 21'h00FFFD;
	localparam logic [CpWidth-1:0] MaxScalar  = 21'h10FFFF;
	localparam logic [CpWidth-1:0] SurrLow    = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrHigh   = 21'h00DFFF;
	localparam logic [CpWidth-1:0] Least2Byte = 21'h000080;
	localparam logic [CpWidth-1:0] Least3Byte = 21'h000800;
	localparam logic [CpWidth-1:0] Least4Byte = 21'h010000;

	// Job for the result side: pre_cnt replacements, then an optional
	// middle result, then post_cnt replacements.
	typedef struct packed {
		logic [1:0]         pre_cnt;
		logic               has_mid;
		logic [CpWidth-1:0] mid_cp;
		logic               mid_rep;
		logic [1:0]         post_cnt;
	} job_t;

	// Smallest scalar that a sequence with the given number of continuation
	// bytes may legally encode.
	function automatic logic [CpWidth-1:0] least_for(input logic [1:0] extra);
		logic [CpWidth-1:0] least;
		case (extra)
			2'd1:    least = Least2Byte;
			2'd2:    least = Least3Byte;
			default: least = Least4Byte;
		endcase
		return least;
	endfunction

endpackage

@@ sv/u8sd_front.sv @@
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts bytes, tracks the pending sequence and issues at most one job per byte.
// ----------------------------------------------------------------------------
module u8sd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              end_of_text,
	input  logic              full,
	output logic              push,
	output u8sd_pkg::job_t    job
);

	logic [u8sd_pkg::CpWidth-1:0] partial_q;
	logic [1:0]                   expected_q;
	logic [1:0]                   seen_q;

	logic [u8sd_pkg::CpWidth-1:0] partial_n;
	logic [1:0]                   expected_n;
	logic [1:0]                   seen_n;
	logic [u8sd_pkg::CpWidth-1:0] shifted;
	logic [1:0]                   seen_inc;
	logic                         pending;
	logic                         is_cont;
	logic                         consumed;
	logic                         accept;
	logic [2:0]                   total;

	assign pending  = (expected_q != 2'd0);
	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign consumed = pending && is_cont;
	assign shifted  = {partial_q[u8sd_pkg::CpWidth-7:0], in_byte[5:0]};
	assign seen_inc = seen_q + 2'd1;

	always_comb begin
		partial_n    = partial_q;
		expected_n   = expected_q;
		seen_n       = seen_q;
		job.pre_cnt  = 2'd0;
		job.has_mid  = 1'b0;
		job.mid_cp   = u8sd_pkg::ReplChar;
		job.mid_rep  = 1'b1;
		job.post_cnt = 2'd0;

		if (pending) begin
			if (is_cont) begin
				partial_n = shifted;
				seen_n    = seen_inc;
				if (seen_inc >= expected_q) begin
					job.has_mid = 1'b1;
					if (shifted < u8sd_pkg::least_for(expected_q) ||
					    (shifted >= u8sd_pkg::SurrLow && shifted <= u8sd_pkg::SurrHigh) ||
					    shifted > u8sd_pkg::MaxScalar) begin
						job.mid_cp  = u8sd_pkg::ReplChar;
						job.mid_rep = 1'b1;
					end else begin
						job.mid_cp  = shifted;
						job.mid_rep = 1'b0;
					end
					partial_n  = '0;
					expected_n = 2'd0;
					seen_n     = 2'd0;
				end
			end else begin
				// Cut short: one replacement for the lead and one per held byte.
				job.pre_cnt = seen_q + 2'd1;
				partial_n   = '0;
				expected_n  = 2'd0;
				seen_n      = 2'd0;
			end
		end

		if (!consumed) begin
			if (in_byte[7] == 1'b0) begin
				job.has_mid = 1'b1;
				job.mid_cp  = {{(u8sd_pkg::CpWidth-8){1'b0}}, in_byte};
				job.mid_rep = 1'b0;
			end else if (in_byte[7:5] == 3'b110) begin
				partial_n  = {{(u8sd_pkg::CpWidth-5){1'b0}}, in_byte[4:0]};
				expected_n = 2'd1;
				seen_n     = 2'd0;
			end else if (in_byte[7:4] == 4'b1110) begin
				partial_n  = {{(u8sd_pkg::CpWidth-4){1'b0}}, in_byte[3:0]};
				expected_n = 2'd2;
				seen_n     = 2'd0;
			end else if (in_byte[7:3] == 5'b11110) begin
				partial_n  = {{(u8sd_pkg::CpWidth-3){1'b0}}, in_byte[2:0]};
				expected_n = 2'd3;
				seen_n     = 2'd0;
			end else begin
				job.has_mid = 1'b1;
				job.mid_cp  = u8sd_pkg::ReplChar;
				job.mid_rep = 1'b1;
			end
		end

		if (end_of_text && expected_n != 2'd0) begin
			job.post_cnt = seen_n + 2'd1;
			partial_n    = '0;
			expected_n   = 2'd0;
			seen_n       = 2'd0;
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign total    = {1'b0, job.pre_cnt} + {2'b00, job.has_mid} + {1'b0, job.post_cnt};
	// A byte that only opens or extends a sequence leaves nothing to emit.
	assign push     = accept && (total != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			expected_q <= 2'd0;
			seen_q     <= 2'd0;
		end else if (accept) begin
			partial_q  <= partial_n;
			expected_q <= expected_n;
			seen_q     <= seen_n;
		end
	end

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(expected_q == 2'd0) ? (seen_q == 2'd0) : (seen_q < expected_q))
		else $error("front: continuation count outside the pending sequence");

endmodule

@@ sv/u8sd_queue.sv @@
// ----------------------------------------------------------------------------
// u8sd_queue
// Small first-in first-out buffer of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module u8sd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8sd_pkg::job_t    push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output u8sd_pkg::job_t    head_job
);

	localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntWidth = $clog2(DEPTH + 1);
	localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
	localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

	u8sd_pkg::job_t       slot_q [DEPTH];
	logic [PtrWidth-1:0]  wr_ptr_q;
	logic [PtrWidth-1:0]  rd_ptr_q;
	logic [CntWidth-1:0]  count_q;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue: job written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue: job taken while empty");

endmodule

@@ sv/u8sd_back.sv @@
// ----------------------------------------------------------------------------
// u8sd_back
// Expands each job into its code points, one beat per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module u8sd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  u8sd_pkg::job_t                head_job,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [u8sd_pkg::CpWidth-1:0]  code_point,
	output logic                          replaced,
	output logic                          run_last
);

	logic [1:0]                   idx_q;
	logic                         out_valid_q;
	logic [u8sd_pkg::CpWidth-1:0] code_point_q;
	logic                         replaced_q;
	logic                         run_last_q;

	logic                         load;
	logic [2:0]                   total;
	logic                         is_last;
	logic [u8sd_pkg::CpWidth-1:0] cur_cp;
	logic                         cur_rep;

	assign total   = {1'b0, head_job.pre_cnt} + {2'b00, head_job.has_mid}
	               + {1'b0, head_job.post_cnt};
	assign is_last = ({1'b0, idx_q} == total - 3'd1);
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_comb begin
		if (idx_q == head_job.pre_cnt && head_job.has_mid) begin
			cur_cp  = head_job.mid_cp;
			cur_rep = head_job.mid_rep;
		end else begin
			cur_cp  = u8sd_pkg::ReplChar;
			cur_rep = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_point_q <= cur_cp;
			replaced_q   <= cur_rep;
			run_last_q   <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign replaced   = replaced_q;
	assign run_last   = run_last_q;

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> head_valid)
		else $error("back: job left the queue before all its beats were sent");

	a_repl_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && replaced_q) |-> (code_point_q == u8sd_pkg::ReplChar))
		else $error("back: replacement beat carries a code point other than U+FFFD");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < total))
		else $error("back: beat index beyond the job length");

endmodule

@@ sv/utf8_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to Unicode code point decoder.
//
//   Channel | Handshake          | Payload                            | Beat
//   --------+--------------------+------------------------------------+-----------
//   input   | in_valid, in_stall | in_byte[7:0], end_of_text          | one byte
//   output  | out_valid,         | code_point[20:0], replaced,        | one code
//           | out_stall          | run_last                           | point
//
// A byte is taken every cycle while the job queue has room; each byte yields
// zero to four code points, and the back part sends one per cycle while
// out_stall is low. The first code point of a byte passes through the job
// queue and then the output register.
// Reset clears the pending sequence, the job queue (QUEUE_DEPTH entries) and
// the output valid flag.
// in_stall rises only when the queue is full; out_stall holds the output
// register and, through the queue, eventually the input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [u8sd_pkg::CpWidth-1:0]  code_point,
	output logic                          replaced,
	output logic                          run_last
);

	logic            full;
	logic            push;
	logic            pop;
	logic            head_valid;
	u8sd_pkg::job_t  push_job;
	u8sd_pkg::job_t  head_job;

	u8sd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.full        (full),
		.push        (push),
		.job         (push_job)
	);

	u8sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u8sd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.replaced   (replaced),
		.run_last   (run_last)
	);

endmodule
